@@ rtl/core/asrs_pkg.sv @@
// Shared constants, request types and register codes for the anchor successor range selector.
`timescale 1ns / 1ps
`default_nettype none
package asrs_pkg;

  localparam int WIN_DEPTH  = 64;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

  localparam int X_W        = 32;
  localparam int TAG_W      = 32;
  localparam int ENT_W      = TAG_W + X_W;
  localparam int DIST_W     = 31;
  localparam int ITER_W     = 6;
  localparam int RANGE_W    = 6;
  localparam int LIM_W      = (ITER_W > CNT_W) ? ITER_W : CNT_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam int IQ_DEPTH   = 2;
  localparam int IQ_AW      = $clog2(IQ_DEPTH);
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_AW      = $clog2(RQ_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_LIMIT = 1'b1;

  localparam logic [DIST_W-1:0] GAP_LIMIT_RST  = 31'd5000;
  localparam logic [ITER_W-1:0] LOOK_LIMIT_RST = 6'd63;

  typedef struct packed {
    logic [X_W-1:0]   anchor_x;
    logic [TAG_W-1:0] strand_ref_tag;
    logic             last_of_read;
  } item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] successor_range;
    logic               cut_after;
    logic               run_last;
  } res_t;

  typedef struct packed {
    logic [DIST_W-1:0] gap_limit;
    logic [ITER_W-1:0] look_limit;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/asrs_front.sv @@
// Front end: configuration registers and the input request queue.
`timescale 1ns / 1ps
`default_nettype none
module asrs_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  wire  asrs_pkg::item_t                in_item,
  input  wire                                  cfg_we,
  input  wire  [asrs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire  [asrs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output asrs_pkg::cfg_t                       cfg,
  input  wire                                  iq_pop,
  output logic                                 iq_empty,
  output asrs_pkg::item_t                      iq_item
);

  asrs_pkg::item_t                q_mem_r [asrs_pkg::IQ_DEPTH];
  logic [asrs_pkg::IQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [asrs_pkg::IQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [asrs_pkg::IQ_AW:0]       count_r, count_nxt;
  asrs_pkg::cfg_t                 cfg_r, cfg_nxt;
  logic                           do_push, do_pop;

  assign in_full  = (count_r == (asrs_pkg::IQ_AW + 1)'(asrs_pkg::IQ_DEPTH));
  assign iq_empty = (count_r == '0);
  assign iq_item  = q_mem_r[rd_ptr_r];
  assign cfg      = cfg_r;
  assign do_push  = in_push && !in_full;
  assign do_pop   = iq_pop && !iq_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + asrs_pkg::IQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + asrs_pkg::IQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (asrs_pkg::IQ_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (asrs_pkg::IQ_AW + 1)'(1);
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we && cfg_idx == asrs_pkg::REG_GAP_LIMIT) begin
      cfg_nxt.gap_limit = cfg_wdata[asrs_pkg::DIST_W-1:0];
    end
    if (cfg_we && cfg_idx == asrs_pkg::REG_LOOK_LIMIT) begin
      cfg_nxt.look_limit = cfg_wdata[asrs_pkg::ITER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      cfg_r.gap_limit  <= asrs_pkg::GAP_LIMIT_RST;
      cfg_r.look_limit <= asrs_pkg::LOOK_LIMIT_RST;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      cfg_r    <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/asrs_back.sv @@
// Back end: anchor window, successor test and resolution sequencer.
`timescale 1ns / 1ps
`default_nettype none
module asrs_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire asrs_pkg::cfg_t     cfg,
  input  wire                     iq_empty,
  input  wire asrs_pkg::item_t    iq_item,
  output logic                    iq_pop,
  output logic                    res_push,
  output asrs_pkg::res_t          res_out,
  input  wire                     res_full
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TEST = 3'b010,
    ST_CAP  = 3'b100
  } st_t;

  st_t                                st_r, st_nxt;
  logic [asrs_pkg::WIN_AW-1:0]        head_r, head_nxt;
  logic [asrs_pkg::CNT_W-1:0]         pend_r, pend_nxt;
  logic                               hold_vld_r, hold_vld_nxt;
  logic [asrs_pkg::RANGE_W-1:0]       hold_range_r, hold_range_nxt;
  asrs_pkg::item_t                    item_r;
  logic [asrs_pkg::ENT_W-1:0]         win_mem [asrs_pkg::WIN_DEPTH];
  logic [asrs_pkg::ENT_W-1:0]         head_ent_r;

  logic [asrs_pkg::LIM_W-1:0]         lim;
  logic [asrs_pkg::LIM_W-1:0]         pend_w, pend_m1_w, range_w;
  logic [asrs_pkg::RANGE_W-1:0]       range_now;
  logic signed [asrs_pkg::X_W:0]      x_ext, reach_ext;
  logic [asrs_pkg::TAG_W-1:0]         ent_tag;
  logic [asrs_pkg::X_W-1:0]           ent_x;
  logic                               fail, can_emit, take, resolve, append, finish;
  logic [asrs_pkg::WIN_AW-1:0]        waddr;
  logic [asrs_pkg::ENT_W-1:0]         wdata;

  always_comb begin
    if (asrs_pkg::LIM_W'(cfg.look_limit) > asrs_pkg::LIM_W'(asrs_pkg::WIN_DEPTH - 1)) begin
      lim = asrs_pkg::LIM_W'(asrs_pkg::WIN_DEPTH - 1);
    end else begin
      lim = asrs_pkg::LIM_W'(cfg.look_limit);
    end
  end

  assign pend_w    = asrs_pkg::LIM_W'(pend_r);
  assign pend_m1_w = asrs_pkg::LIM_W'(pend_r - asrs_pkg::CNT_W'(1));
  assign range_w   = (pend_m1_w < lim) ? pend_m1_w : lim;
  assign range_now = range_w[asrs_pkg::RANGE_W-1:0];

  assign ent_tag   = head_ent_r[asrs_pkg::ENT_W-1:asrs_pkg::X_W];
  assign ent_x     = head_ent_r[asrs_pkg::X_W-1:0];
  assign x_ext     = $signed({item_r.anchor_x[asrs_pkg::X_W-1], item_r.anchor_x});
  assign reach_ext = $signed({ent_x[asrs_pkg::X_W-1], ent_x})
                   + $signed({2'b00, cfg.gap_limit});
  assign fail      = (ent_tag != item_r.strand_ref_tag) || (x_ext > reach_ext);

  assign can_emit  = !hold_vld_r || !res_full;
  assign waddr     = head_r + pend_r[asrs_pkg::WIN_AW-1:0];
  assign wdata     = {item_r.strand_ref_tag, item_r.anchor_x};
  assign iq_pop    = take;

  always_comb begin
    st_nxt         = st_r;
    head_nxt       = head_r;
    pend_nxt       = pend_r;
    hold_vld_nxt   = hold_vld_r;
    hold_range_nxt = hold_range_r;
    take           = 1'b0;
    resolve        = 1'b0;
    append         = 1'b0;
    finish         = 1'b0;
    res_push       = 1'b0;
    res_out        = '0;

    unique case (st_r)
      ST_IDLE: begin
        take = !iq_empty;
      end
      ST_TEST: begin
        if (pend_r != '0 && fail) begin
          resolve = can_emit;
        end else begin
          append = 1'b1;
        end
      end
      ST_CAP: begin
        if (pend_w > lim || (item_r.last_of_read && pend_r != '0)) begin
          resolve = can_emit;
        end else if (can_emit) begin
          finish = 1'b1;
          take   = !iq_empty;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (append) begin
      pend_nxt = pend_r + asrs_pkg::CNT_W'(1);
      st_nxt   = ST_CAP;
    end

    // retire the oldest anchor; the previous result leaves the hold stage
    if (resolve) begin
      pend_nxt       = pend_r - asrs_pkg::CNT_W'(1);
      head_nxt       = head_r + asrs_pkg::WIN_AW'(1);
      res_push       = hold_vld_r;
      res_out        = '{successor_range: hold_range_r,
                         cut_after:       (hold_range_r == '0),
                         run_last:        1'b0};
      hold_vld_nxt   = 1'b1;
      hold_range_nxt = range_now;
    end

    // close the request: the held result is its final one
    if (finish) begin
      res_push     = hold_vld_r;
      res_out      = '{successor_range: hold_range_r,
                       cut_after:       (hold_range_r == '0),
                       run_last:        1'b1};
      hold_vld_nxt = 1'b0;
      st_nxt       = ST_IDLE;
    end

    if (take) begin
      st_nxt = ST_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      head_r     <= '0;
      pend_r     <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      head_r     <= head_nxt;
      pend_r     <= pend_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_range_r <= hold_range_nxt;
    if (take) begin
      item_r <= iq_item;
    end
  end

  // keep the oldest entry registered; bypass a write into the head slot
  always_ff @(posedge clk) begin
    if (append) begin
      win_mem[waddr] <= wdata;
    end
    if (append && waddr == head_nxt) begin
      head_ent_r <= wdata;
    end else begin
      head_ent_r <= win_mem[head_nxt];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_resolve_count: assert property (@(posedge clk) disable iff (!rst_n)
    resolve |=> pend_r == $past(pend_r) - asrs_pkg::CNT_W'(1))
    else $error("pending count did not drop on resolve");

  a_resolve_head: assert property (@(posedge clk) disable iff (!rst_n)
    resolve |=> head_r == $past(head_r) + asrs_pkg::WIN_AW'(1))
    else $error("head pointer did not advance on resolve");

  a_read_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && item_r.last_of_read) |=> pend_r == '0)
    else $error("window not empty after read end");

endmodule
`default_nettype wire

@@ rtl/core/asrs_resq.sv @@
// Result queue between the back end and the output ports.
`timescale 1ns / 1ps
`default_nettype none
module asrs_resq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 res_push,
  input  wire asrs_pkg::res_t res_in,
  output logic                res_full,
  input  wire                 pop,
  output logic                empty,
  output asrs_pkg::res_t      res_head
);

  asrs_pkg::res_t                 q_mem_r [asrs_pkg::RQ_DEPTH];
  logic [asrs_pkg::RQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [asrs_pkg::RQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [asrs_pkg::RQ_AW:0]       count_r, count_nxt;
  logic                           do_push, do_pop;

  assign res_full = (count_r == (asrs_pkg::RQ_AW + 1)'(asrs_pkg::RQ_DEPTH));
  assign empty    = (count_r == '0);
  assign res_head = q_mem_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + asrs_pkg::RQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + asrs_pkg::RQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (asrs_pkg::RQ_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (asrs_pkg::RQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= res_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/anchor_successor_range_select.sv @@
// Top level of the anchor successor range selector.
//
//   channel   direction  handshake            payload
//   in_       request in push / full          anchor_x, strand_ref_tag, last_of_read
//   out_      result out empty / pop          successor_range, cut_after, run_last
//   cfg_      write in   cfg_we               cfg_idx, cfg_wdata
//
// An anchor visits ST_TEST and ST_CAP, plus one resolve step per anchor it retires;
// the window memory is walked one head entry per cycle unless resolution stalls.
// Synchronous reset empties both queues and the window count; window contents stay.
// A full result queue stalls resolution; a 2-entry input queue takes requests meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module anchor_successor_range_select (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_push,
  output logic                                in_full,
  input  wire signed [asrs_pkg::X_W-1:0]      in_anchor_x,
  input  wire        [asrs_pkg::TAG_W-1:0]    in_strand_ref_tag,
  input  wire                                 in_last_of_read,
  output logic                                out_empty,
  input  wire                                 out_pop,
  output logic       [asrs_pkg::RANGE_W-1:0]  out_successor_range,
  output logic                                out_cut_after,
  output logic                                out_run_last,
  input  wire                                 cfg_we,
  input  wire        [asrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire        [asrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  asrs_pkg::item_t  in_item;
  asrs_pkg::item_t  iq_item;
  asrs_pkg::cfg_t   cfg;
  asrs_pkg::res_t   res_in;
  asrs_pkg::res_t   res_head;
  logic             iq_empty;
  logic             iq_pop;
  logic             res_push;
  logic             res_full;

  assign in_item = '{anchor_x:       in_anchor_x,
                     strand_ref_tag: in_strand_ref_tag,
                     last_of_read:   in_last_of_read};

  assign out_successor_range = res_head.successor_range;
  assign out_cut_after       = res_head.cut_after;
  assign out_run_last        = res_head.run_last;

  asrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .iq_pop    (iq_pop),
    .iq_empty  (iq_empty),
    .iq_item   (iq_item)
  );

  asrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .iq_empty  (iq_empty),
    .iq_item   (iq_item),
    .iq_pop    (iq_pop),
    .res_push  (res_push),
    .res_out   (res_in),
    .res_full  (res_full)
  );

  asrs_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_in    (res_in),
    .res_full  (res_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .res_head  (res_head)
  );

endmodule
`default_nettype wire

@@ verif/tb_anchor_successor_range_select.sv @@
// Self-checking testbench for the anchor successor range selector, with a built-in window predictor.
`timescale 1ns / 1ps
module tb_anchor_successor_range_select;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 55;

  localparam int X_W        = asrs_pkg::X_W;
  localparam int TAG_W      = asrs_pkg::TAG_W;
  localparam int RANGE_W    = asrs_pkg::RANGE_W;
  localparam int CFG_IDX_W  = asrs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = asrs_pkg::CFG_DATA_W;
  localparam int WIN_DEPTH  = asrs_pkg::WIN_DEPTH;
  localparam int WIN_AW     = asrs_pkg::WIN_AW;
  localparam int DIST_W     = asrs_pkg::DIST_W;
  localparam int ITER_W     = asrs_pkg::ITER_W;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_push           = 1'b0;
  logic                  in_full;
  logic signed [X_W-1:0] in_anchor_x       = '0;
  logic [TAG_W-1:0]      in_strand_ref_tag = '0;
  logic                  in_last_of_read   = 1'b0;
  logic                  out_empty;
  logic                  out_pop           = 1'b0;
  logic [RANGE_W-1:0]    out_successor_range;
  logic                  out_cut_after;
  logic                  out_run_last;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx           = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  // predictor state
  logic [TAG_W-1:0]      win_tag [WIN_DEPTH];
  logic signed [X_W-1:0] win_x   [WIN_DEPTH];
  int unsigned           pend_cnt   = 0;
  logic [WIN_AW-1:0]     head_ptr   = '0;
  logic [DIST_W-1:0]     dist_limit = asrs_pkg::GAP_LIMIT_RST;
  logic [ITER_W-1:0]     iter_limit = asrs_pkg::LOOK_LIMIT_RST;
  asrs_pkg::res_t        range_expect_q[$];

  int unsigned mismatch_cnt  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  anchor_successor_range_select dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_anchor_x         (in_anchor_x),
    .in_strand_ref_tag   (in_strand_ref_tag),
    .in_last_of_read     (in_last_of_read),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_successor_range (out_successor_range),
    .out_cut_after       (out_cut_after),
    .out_run_last        (out_run_last),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic asrs_pkg::res_t retire_oldest(int unsigned cap);
    asrs_pkg::res_t r;
    int unsigned    followers;
    followers         = pend_cnt - 1;
    r.successor_range = RANGE_W'((followers < cap) ? followers : cap);
    r.cut_after       = (r.successor_range == '0);
    r.run_last        = 1'b0;
    head_ptr          = head_ptr + 1'b1;
    pend_cnt--;
    return r;
  endfunction

  function automatic void predict_successor_ranges(logic signed [X_W-1:0] ax,
                                                   logic [TAG_W-1:0] tag, logic last);
    asrs_pkg::res_t    step_out[$];
    int unsigned       cap;
    longint            reach;
    logic [WIN_AW-1:0] slot;
    cap = (iter_limit > WIN_DEPTH - 1) ? WIN_DEPTH - 1 : iter_limit;
    while (pend_cnt > 0) begin
      reach = longint'(win_x[head_ptr]) + longint'(dist_limit);
      if (win_tag[head_ptr] != tag || longint'(ax) > reach)
        step_out.push_back(retire_oldest(cap));
      else
        break;
    end
    slot          = head_ptr + WIN_AW'(pend_cnt);
    win_tag[slot] = tag;
    win_x[slot]   = ax;
    pend_cnt++;
    while (pend_cnt > cap)
      step_out.push_back(retire_oldest(cap));
    if (last) begin
      while (pend_cnt > 0)
        step_out.push_back(retire_oldest(cap));
    end
    if (step_out.size() != 0)
      step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i])
      range_expect_q.push_back(step_out[i]);
  endfunction

  task automatic send_anchor(logic signed [X_W-1:0] ax, logic [TAG_W-1:0] tag, logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_anchor_x       <= ax;
    in_strand_ref_tag <= tag;
    in_last_of_read   <= last;
    do @(posedge clk); while (in_full);
    predict_successor_ranges(ax, tag, last);
  endtask

  task automatic quiesce(int unsigned settle);
    in_push <= 1'b0;
    while (range_expect_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_limits(logic [DIST_W-1:0] gap_max, logic [ITER_W-1:0] iter);
    cfg_we    <= 1'b1;
    cfg_idx   <= asrs_pkg::REG_GAP_LIMIT;
    cfg_wdata <= CFG_DATA_W'(gap_max);
    @(posedge clk);
    dist_limit = gap_max;
    cfg_idx   <= asrs_pkg::REG_LOOK_LIMIT;
    cfg_wdata <= CFG_DATA_W'(iter);
    @(posedge clk);
    iter_limit = iter;
    cfg_we    <= 1'b0;
  endtask

  task automatic test_default_limits();
    send_anchor(32'sd100, 32'h0000_0001, 1'b0);
    send_anchor(32'sd200, 32'h0000_0001, 1'b0);
    send_anchor(32'sd5100, 32'h0000_0001, 1'b0);
    send_anchor(32'sd5101, 32'h0000_0001, 1'b0);
    send_anchor(32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_anchor(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_anchor(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_anchor(32'sd0, 32'h0000_0000, 1'b1);
    quiesce(SETTLE_CYCLES);
  endtask

  task automatic test_unsorted_anchors();
    send_anchor(32'sd9000, 32'h5A5A_A5A5, 1'b0);
    send_anchor(32'sd4000, 32'h5A5A_A5A5, 1'b0);
    send_anchor(32'sd12000, 32'h5A5A_A5A5, 1'b0);
    send_anchor(-32'sd3000, 32'h5A5A_A5A5, 1'b0);
    send_anchor(32'sd14001, 32'h5A5A_A5A5, 1'b1);
    quiesce(SETTLE_CYCLES);
  endtask

  task automatic test_limit_extremes();
    load_limits('0, 6'd1);
    send_anchor(32'sd10, 32'h0000_0002, 1'b0);
    send_anchor(32'sd10, 32'h0000_0002, 1'b0);
    send_anchor(32'sd11, 32'h0000_0002, 1'b0);
    send_anchor(32'sd11, 32'h0000_0002, 1'b1);
    quiesce(SETTLE_CYCLES);
    load_limits(31'h7FFF_FFFF, 6'd2);
    send_anchor(32'sh8000_0000, 32'h0000_0003, 1'b0);
    send_anchor(32'sh7FFF_FFFF, 32'h0000_0003, 1'b0);
    send_anchor(32'sd0, 32'h0000_0003, 1'b0);
    send_anchor(32'sd5, 32'h0000_0003, 1'b1);
    quiesce(SETTLE_CYCLES);
    load_limits(31'd100, 6'd0);
    send_anchor(32'sd1, 32'h0000_0004, 1'b0);
    send_anchor(32'sd2, 32'h0000_0004, 1'b1);
    quiesce(SETTLE_CYCLES);
  endtask

  task automatic test_cap_lowered_mid_read();
    load_limits(asrs_pkg::GAP_LIMIT_RST, asrs_pkg::LOOK_LIMIT_RST);
    for (int i = 0; i < 5; i++)
      send_anchor(X_W'(i), 32'h0000_0005, 1'b0);
    quiesce(SETTLE_CYCLES);
    load_limits(asrs_pkg::GAP_LIMIT_RST, 6'd2);
    send_anchor(32'sd5, 32'h0000_0005, 1'b1);
    quiesce(SETTLE_CYCLES);
  endtask

  task automatic test_output_backpressure();
    load_limits(asrs_pkg::GAP_LIMIT_RST, 6'd1);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++)
      send_anchor(X_W'(i * 3), 32'h0000_0006, i == 29);
    // hold the sender until everything has been delivered
    quiesce(0);
    for (int i = 0; i < 10; i++)
      send_anchor(X_W'(i), 32'h0000_0007, i == 9);
    quiesce(SETTLE_CYCLES);
  endtask

  task automatic test_random_reads(int unsigned idle_pct, int unsigned stall_pct,
                                   logic [DIST_W-1:0] gap_max, logic [ITER_W-1:0] iter);
    int unsigned           sent;
    int unsigned           len;
    int unsigned           step;
    bit                    noisy;
    logic signed [X_W-1:0] ax;
    logic [TAG_W-1:0]      tag;
    quiesce(SETTLE_CYCLES);
    load_limits(gap_max, iter);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len   = ($urandom_range(29) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
      noisy = ($urandom_range(9) < 2);
      ax    = $urandom();
      tag   = $urandom();
      for (int i = 0; i < len; i++) begin
        if (noisy) begin
          send_anchor($urandom(), tag ^ TAG_W'($urandom_range(1)), $urandom_range(7) == 0);
        end else begin
          if ($urandom_range(5) == 0)
            tag = $urandom();
          send_anchor(ax, tag, i == len - 1);
          case ($urandom_range(3))
            0: step = 0;
            1: step = $urandom_range(0, (gap_max > 1000) ? 1000 : gap_max);
            2: step = gap_max + $urandom_range(1, 10);
            default: step = $urandom_range(0, gap_max);
          endcase
          ax = ax + X_W'(step);
        end
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : pop_side
    asrs_pkg::res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (range_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result: range %0d cut %0b last %0b",
                     out_successor_range, out_cut_after, out_run_last);
        end else begin
          want = range_expect_q.pop_front();
          if (out_successor_range !== want.successor_range ||
              out_cut_after !== want.cut_after || out_run_last !== want.run_last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display(
                "mismatch: want range %0d cut %0b last %0b, got range %0d cut %0b last %0b",
                want.successor_range, want.cut_after, want.run_last,
                out_successor_range, out_cut_after, out_run_last);
          end
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limits();
    test_unsorted_anchors();
    test_limit_extremes();
    test_cap_lowered_mid_read();
    test_output_backpressure();
    test_random_reads(0, 0, 31'd2000, 6'd63);
    test_random_reads(50, 0, 31'h7FFF_FFFF, 6'd1);
    test_random_reads(0, 50, '0, 6'd7);
    test_random_reads(15, 15, DIST_W'($urandom()), ITER_W'($urandom_range(1, 63)));
    quiesce(SETTLE_CYCLES);
    mismatch_cnt += range_expect_q.size();
    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
